@@ hw/rtl/rmq_pkg.sv @@
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared widths, branch codes and item types of the matrix to quaternion
// converter.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 29;

  // root argument in signed form, then its positive magnitude
  localparam int ARG_W  = DATA_WIDTH + 3;
  localparam int ARGU_W = DATA_WIDTH + 1;
  // divided difference or sum of two elements
  localparam int NUM_W  = DATA_WIDTH + 1;
  // root width, radicand is twice as wide
  localparam int S_W    = (DATA_WIDTH + FRAC_BITS + 4) / 2;
  localparam int RAD_W  = 2 * S_W;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [ARG_W-1:0] FX_ONE = ARG_W'(1) << FRAC_BITS;

  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X     = 2'd1;
  localparam logic [1:0] BR_Y     = 2'd2;
  localparam logic [1:0] BR_Z     = 2'd3;

  // classified item: branch, flag and the three numerators in output order
  typedef struct packed {
    logic [1:0]                 branch;
    logic                       degen;
    logic [2:0][NUM_W-1:0]      num;
  } item_t;

  typedef struct packed {
    item_t             item;
    logic [ARGU_W-1:0] arg;
  } entry_t;

endpackage

@@ hw/rtl/rmq_front.sv @@
// ----------------------------------------------------------------------------
// rmq_front
// Accept a matrix, pick the branch, form the root argument and numerators.
// ----------------------------------------------------------------------------
module rmq_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m00_i,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m01_i,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m02_i,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m10_i,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m11_i,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m12_i,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m20_i,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m21_i,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m22_i,
  output logic                                  push_o,
  output rmq_pkg::entry_t                       entry_o,
  input  logic                                  full_i
);
  import rmq_pkg::*;

  logic              vld_q;
  entry_t            ent_q, ent_d;
  logic              load;
  logic signed [ARG_W-1:0] trace, arg;
  logic signed [NUM_W-1:0] d_zy, d_xz, d_yx, s_xy, s_xz, s_yz;

  assign push_o     = vld_q & ~full_i;
  assign in_stall_o = vld_q & full_i;
  assign load       = in_valid_i & ~in_stall_o;
  assign entry_o    = ent_q;

  // classify the matrix
  always_comb begin
    trace = ARG_W'(m00_i) + ARG_W'(m11_i) + ARG_W'(m22_i);
    d_zy  = NUM_W'(m21_i) - NUM_W'(m12_i);
    d_xz  = NUM_W'(m02_i) - NUM_W'(m20_i);
    d_yx  = NUM_W'(m10_i) - NUM_W'(m01_i);
    s_xy  = NUM_W'(m01_i) + NUM_W'(m10_i);
    s_xz  = NUM_W'(m02_i) + NUM_W'(m20_i);
    s_yz  = NUM_W'(m12_i) + NUM_W'(m21_i);
    if (trace > 0) begin
      ent_d.item.branch = BR_TRACE;
      arg = FX_ONE + trace;
      ent_d.item.num = {d_yx, d_xz, d_zy};
    end else if (m00_i > m11_i && m00_i > m22_i) begin
      ent_d.item.branch = BR_X;
      arg = FX_ONE + ARG_W'(m00_i) - ARG_W'(m11_i) - ARG_W'(m22_i);
      ent_d.item.num = {s_xz, s_xy, d_zy};
    end else if (m11_i > m22_i) begin
      ent_d.item.branch = BR_Y;
      arg = FX_ONE + ARG_W'(m11_i) - ARG_W'(m00_i) - ARG_W'(m22_i);
      ent_d.item.num = {s_yz, s_xy, d_xz};
    end else begin
      ent_d.item.branch = BR_Z;
      arg = FX_ONE + ARG_W'(m22_i) - ARG_W'(m00_i) - ARG_W'(m11_i);
      ent_d.item.num = {s_yz, s_xz, d_yx};
    end
    ent_d.item.degen = (arg <= 0);
    ent_d.arg = arg[ARGU_W-1:0];
  end

  // hold the item until the queue takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load) begin
      vld_q <= 1'b1;
    end else if (push_o) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ent_q <= ent_d;
    end
  end

endmodule

@@ hw/rtl/rmq_fifo.sv @@
// ----------------------------------------------------------------------------
// rmq_fifo
// Short queue between the classifier and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module rmq_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rmq_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output rmq_pkg::entry_t entry_o
);
  import rmq_pkg::*;

  entry_t          mem_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_q, rd_q;
  logic [Q_AW:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == (Q_AW+1)'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign entry_o = mem_q[rd_q];

  // advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

@@ hw/rtl/rmq_sqrt.sv @@
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one root bit per stage, s = 2*sqrt(arg).
// ----------------------------------------------------------------------------
module rmq_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  rmq_pkg::entry_t           entry_i,
  output logic                      valid_o,
  output logic [rmq_pkg::S_W-1:0]   root_o,
  output rmq_pkg::item_t            item_o
);
  import rmq_pkg::*;

  logic             vld_q  [S_W];
  logic [S_W+1:0]   rem_q  [S_W];
  logic [S_W-1:0]   root_q [S_W];
  logic [RAD_W-1:0] rad_q  [S_W];
  item_t            item_q [S_W];
  logic [RAD_W-1:0] rad0;

  assign rad0 = RAD_W'({entry_i.arg, {(FRAC_BITS + 2){1'b0}}});

  for (genvar k = 0; k < S_W; k++) begin : g_stage
    logic             vin;
    logic [S_W+1:0]   rin, rsh, trial;
    logic [S_W-1:0]   qin;
    logic [RAD_W-1:0] din;
    item_t            iin;

    if (k == 0) begin : g_first
      assign vin = valid_i;
      assign rin = '0;
      assign qin = '0;
      assign din = rad0;
      assign iin = entry_i.item;
    end else begin : g_next
      assign vin = vld_q[k-1];
      assign rin = rem_q[k-1];
      assign qin = root_q[k-1];
      assign din = rad_q[k-1];
      assign iin = item_q[k-1];
    end

    assign rsh   = {rin[S_W-1:0], din[RAD_W-1 -: 2]};
    assign trial = {qin, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vin;
      end
    end

    // try one root bit
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        item_q[k] <= iin;
        rad_q[k]  <= din << 2;
        if (rsh >= trial) begin
          rem_q[k]  <= rsh - trial;
          root_q[k] <= {qin[S_W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= rsh;
          root_q[k] <= {qin[S_W-2:0], 1'b0};
        end
      end
    end
  end

  assign valid_o = vld_q[S_W-1];
  assign root_o  = root_q[S_W-1];
  assign item_o  = item_q[S_W-1];

endmodule

@@ hw/rtl/rmq_div.sv @@
// ----------------------------------------------------------------------------
// rmq_div
// Three lanes of pipelined restoring division, (num << FRAC_BITS) / s,
// one quotient bit per stage, with overflow detection up front.
// ----------------------------------------------------------------------------
module rmq_div (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       en_i,
  input  logic                                       valid_i,
  input  logic [rmq_pkg::S_W-1:0]                    root_i,
  input  rmq_pkg::item_t                             item_i,
  output logic                                       valid_o,
  output logic [rmq_pkg::S_W-1:0]                    root_o,
  output rmq_pkg::item_t                             item_o,
  output logic [2:0][rmq_pkg::DATA_WIDTH-1:0]        mag_o,
  output logic [2:0]                                 neg_o,
  output logic [2:0]                                 ovf_o
);
  import rmq_pkg::*;

  localparam int NST = DATA_WIDTH + 1;
  localparam int SH  = DATA_WIDTH - FRAC_BITS;
  localparam int CW  = S_W + NUM_W + SH;

  logic                        vld_q  [NST];
  logic [S_W-1:0]              s_q    [NST];
  item_t                       item_q [NST];
  logic [2:0][S_W:0]           r_q    [NST];
  logic [2:0][DATA_WIDTH-1:0]  lo_q   [NST];
  logic [2:0][DATA_WIDTH-1:0]  q_q    [NST];
  logic [2:0]                  neg_q  [NST];
  logic [2:0]                  ovf_q  [NST];

  // prepare magnitudes, first remainder and overflow
  for (genvar l = 0; l < 3; l++) begin : g_prep
    logic [NUM_W-1:0] num, mag;
    logic [CW-1:0]    wide;

    assign num  = item_i.num[l];
    assign mag  = num[NUM_W-1] ? (~num + 1'b1) : num;
    assign wide = CW'(mag);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[0][l]   <= wide[SH +: (S_W + 1)];
        lo_q[0][l]  <= {mag[SH-1:0], {FRAC_BITS{1'b0}}};
        q_q[0][l]   <= '0;
        neg_q[0][l] <= num[NUM_W-1];
        ovf_q[0][l] <= wide >= (CW'(root_i) << SH);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q[0]    <= root_i;
      item_q[0] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k < NST; k++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[k]    <= s_q[k-1];
        item_q[k] <= item_q[k-1];
        neg_q[k]  <= neg_q[k-1];
        ovf_q[k]  <= ovf_q[k-1];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [S_W:0] rsh;

      assign rsh = {r_q[k-1][l][S_W-1:0], lo_q[k-1][l][DATA_WIDTH-1]};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          lo_q[k][l] <= lo_q[k-1][l] << 1;
          if (rsh >= {1'b0, s_q[k-1]}) begin
            r_q[k][l] <= rsh - {1'b0, s_q[k-1]};
            q_q[k][l] <= {q_q[k-1][l][DATA_WIDTH-2:0], 1'b1};
          end else begin
            r_q[k][l] <= rsh;
            q_q[k][l] <= {q_q[k-1][l][DATA_WIDTH-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign valid_o = vld_q[NST-1];
  assign root_o  = s_q[NST-1];
  assign item_o  = item_q[NST-1];
  assign mag_o   = q_q[NST-1];
  assign neg_o   = neg_q[NST-1];
  assign ovf_o   = ovf_q[NST-1];

endmodule

@@ hw/rtl/rotation_matrix_to_quaternion.sv @@
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Direction cosine matrix to unit quaternion, Shepperd's method, Q2.29.
// ----------------------------------------------------------------------------
// Path: front register, queue, the one-bit-per-stage root and divider
// pipelines, then the output register.
// Throughput: one item per cycle while neither side stalls; the front and
// back stall independently through a four-entry queue.
// Reset: asynchronous, clears all valid flags and queue pointers at once.
module rotation_matrix_to_quaternion (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m00_i,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m01_i,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m02_i,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m10_i,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m11_i,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m12_i,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m20_i,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m21_i,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m22_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [rmq_pkg::DATA_WIDTH-1:0] quat_w_o,
  output logic signed [rmq_pkg::DATA_WIDTH-1:0] quat_x_o,
  output logic signed [rmq_pkg::DATA_WIDTH-1:0] quat_y_o,
  output logic signed [rmq_pkg::DATA_WIDTH-1:0] quat_z_o,
  output logic [1:0]                            branch_used_o,
  output logic                                  degenerate_o
);
  import rmq_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int QW = S_W + DW;

  logic            push, full, empty, pop, en;
  entry_t          f_ent, q_ent;
  logic            sq_vld, dv_vld;
  logic [S_W-1:0]  sq_root, dv_root;
  item_t           sq_item, dv_item;
  logic [2:0][DW-1:0] dv_mag;
  logic [2:0]      dv_neg, dv_ovf;

  logic [2:0][DW-1:0] qs;
  logic [DW-1:0]   quarter;
  logic [QW-1:0]   qwide;
  logic [3:0][DW-1:0] comp;

  logic            out_vld_q;
  logic [DW-1:0]   w_q, x_q, y_q, z_q;
  logic [1:0]      br_q;
  logic            dg_q;

  function automatic logic [DW-1:0] sat_fn(input logic [DW-1:0] mag,
                                           input logic neg, input logic ovf);
    logic [DW-1:0] res;
    if (!neg) begin
      res = (ovf || mag[DW-1]) ? {1'b0, {(DW-1){1'b1}}} : mag;
    end else if (ovf || (mag[DW-1] && |mag[DW-2:0])) begin
      res = {1'b1, {(DW-1){1'b0}}};
    end else begin
      res = ~mag + 1'b1;
    end
    return res;
  endfunction

  rmq_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .m00_i, .m01_i, .m02_i, .m10_i, .m11_i, .m12_i, .m20_i, .m21_i, .m22_i,
    .push_o (push),
    .entry_o(f_ent),
    .full_i (full)
  );

  rmq_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i (push),
    .entry_i(f_ent),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .entry_o(q_ent)
  );

  // advance the back pipeline whenever the output slot frees
  assign en  = ~out_vld_q | ~out_stall_i;
  assign pop = en & ~empty;

  rmq_sqrt u_sqrt (
    .clk_i, .rst_ni,
    .en_i   (en),
    .valid_i(~empty),
    .entry_i(q_ent),
    .valid_o(sq_vld),
    .root_o (sq_root),
    .item_o (sq_item)
  );

  rmq_div u_div (
    .clk_i, .rst_ni,
    .en_i   (en),
    .valid_i(sq_vld),
    .root_i (sq_root),
    .item_i (sq_item),
    .valid_o(dv_vld),
    .root_o (dv_root),
    .item_o (dv_item),
    .mag_o  (dv_mag),
    .neg_o  (dv_neg),
    .ovf_o  (dv_ovf)
  );

  // saturate and place components by branch, zero them for degenerate items
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      qs[l] = sat_fn(dv_mag[l], dv_neg[l], dv_ovf[l]);
    end
    qwide   = QW'(dv_root >> 2);
    quarter = sat_fn(qwide[DW-1:0], 1'b0, |qwide[QW-1:DW]);
    case (dv_item.branch)
      BR_TRACE: comp = {qs[2], qs[1], qs[0], quarter};
      BR_X:     comp = {qs[2], qs[1], quarter, qs[0]};
      BR_Y:     comp = {qs[2], quarter, qs[1], qs[0]};
      BR_Z:     comp = {quarter, qs[2], qs[1], qs[0]};
      default:  comp = '0;
    endcase
    if (dv_item.degen) begin
      comp = '0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_q  <= comp[0];
      x_q  <= comp[1];
      y_q  <= comp[2];
      z_q  <= comp[3];
      br_q <= dv_item.branch;
      dg_q <= dv_item.degen;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign quat_w_o      = w_q;
  assign quat_x_o      = x_q;
  assign quat_y_o      = y_q;
  assign quat_z_o      = z_q;
  assign branch_used_o = br_q;
  assign degenerate_o  = dg_q;

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> quat_w_o == 0 && quat_x_o == 0 &&
    quat_y_o == 0 && quat_z_o == 0)
    else $error("degenerate item with nonzero components");

  a_trace_w_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && branch_used_o == BR_TRACE |-> !quat_w_o[DW-1])
    else $error("trace branch gave negative scalar part");

  a_stall_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> full)
    else $error("input stalled while queue has room");

  a_pop_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(quat_x_o) && !$past(pop))
    else $error("pipeline advanced during output stall");

endmodule

@@ tb/rmq_checker.sv @@
// ----------------------------------------------------------------------------
// rmq_checker
// Watches both channels of the matrix to quaternion converter, predicts each
// quaternion from the accepted matrix and compares it field by field.
// ----------------------------------------------------------------------------
module rmq_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  input  logic                                  in_stall_i,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m00_i,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m01_i,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m02_i,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m10_i,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m11_i,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m12_i,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m20_i,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m21_i,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] m22_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_stall_i,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] quat_w_i,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] quat_x_i,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] quat_y_i,
  input  logic signed [rmq_pkg::DATA_WIDTH-1:0] quat_z_i,
  input  logic [1:0]                            branch_used_i,
  input  logic                                  degenerate_i,
  output int                                    fail_count_o,
  output int                                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rmq_pkg::*;

  typedef struct packed {
    logic [3:0][DATA_WIDTH-1:0] q;
    logic [1:0]                 branch;
    logic                       degen;
  } quat_t;

  quat_t expected_quats[$];

  localparam longint QMAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
  localparam longint QMIN = -(64'sd1 <<< (DATA_WIDTH - 1));

  function automatic logic [DATA_WIDTH-1:0] clamp(longint v);
    if (v > QMAX) v = QMAX;
    if (v < QMIN) v = QMIN;
    return v[DATA_WIDTH-1:0];
  endfunction

  // bit-serial floor square root of an unsigned 64-bit value
  function automatic longint root_of(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint ratio(longint n, longint s);
    if (s <= 0) return 0;
    return (n * (64'sd1 <<< FRAC_BITS)) / s;
  endfunction

  // Shepperd conversion of one matrix
  function automatic quat_t convert_matrix(longint a00, a01, a02, a10, a11, a12,
                                           a20, a21, a22);
    quat_t  r;
    longint tr;
    longint rad;
    longint s;
    longint c[4];
    longint one;
    one = 64'sd1 <<< FRAC_BITS;
    c = '{0, 0, 0, 0};
    tr = a00 + a11 + a22;
    r.degen = 1'b0;
    if (tr > 0) begin
      r.branch = BR_TRACE; rad = one + tr;
    end else if (a00 > a11 && a00 > a22) begin
      r.branch = BR_X; rad = one + a00 - a11 - a22;
    end else if (a11 > a22) begin
      r.branch = BR_Y; rad = one + a11 - a00 - a22;
    end else begin
      r.branch = BR_Z; rad = one + a22 - a00 - a11;
    end
    if (rad <= 0) begin
      r.degen = 1'b1;
    end else begin
      s = root_of(longint'(rad) << (FRAC_BITS + 2));
      case (r.branch)
        BR_TRACE: begin
          c[0] = s >>> 2; c[1] = ratio(a21 - a12, s);
          c[2] = ratio(a02 - a20, s); c[3] = ratio(a10 - a01, s);
        end
        BR_X: begin
          c[0] = ratio(a21 - a12, s); c[1] = s >>> 2;
          c[2] = ratio(a01 + a10, s); c[3] = ratio(a02 + a20, s);
        end
        BR_Y: begin
          c[0] = ratio(a02 - a20, s); c[1] = ratio(a01 + a10, s);
          c[2] = s >>> 2; c[3] = ratio(a12 + a21, s);
        end
        default: begin
          c[0] = ratio(a10 - a01, s); c[1] = ratio(a02 + a20, s);
          c[2] = ratio(a12 + a21, s); c[3] = s >>> 2;
        end
      endcase
    end
    for (int i = 0; i < 4; i++) r.q[i] = clamp(c[i]);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;

  // predict on input acceptance, compare on output acceptance
  always @(posedge clk_i) begin
    quat_t want;
    if (rst_ni && in_valid_i && !in_stall_i)
      expected_quats.push_back(convert_matrix(m00_i, m01_i, m02_i, m10_i, m11_i,
                                              m12_i, m20_i, m21_i, m22_i));
    if (rst_ni && out_valid_i && !out_stall_i) begin
      if (expected_quats.size() == 0) begin
        report_mismatch("unexpected item", 0, 0);
      end else begin
        want = expected_quats.pop_front();
        if (quat_w_i !== signed'(want.q[0])) report_mismatch("quat_w", quat_w_i,
                                                             signed'(want.q[0]));
        if (quat_x_i !== signed'(want.q[1])) report_mismatch("quat_x", quat_x_i,
                                                             signed'(want.q[1]));
        if (quat_y_i !== signed'(want.q[2])) report_mismatch("quat_y", quat_y_i,
                                                             signed'(want.q[2]));
        if (quat_z_i !== signed'(want.q[3])) report_mismatch("quat_z", quat_z_i,
                                                             signed'(want.q[3]));
        if (branch_used_i !== want.branch) report_mismatch("branch_used",
                                                           branch_used_i, want.branch);
        if (degenerate_i !== want.degen) report_mismatch("degenerate",
                                                         degenerate_i, want.degen);
      end
    end
    pending_o = expected_quats.size();
  end
endmodule

@@ tb/tb_rotation_matrix_to_quaternion.sv @@
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion
// Drives directed and random matrices through the converter under varying
// sender gaps and receiver stalls; the checker compares every quaternion.
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_quaternion;
  timeunit 1ns;
  timeprecision 1ps;
  import rmq_pkg::*;

  localparam int                   DW  = DATA_WIDTH;
  localparam logic signed [DW-1:0] ONE = DW'(64'sd1 <<< FRAC_BITS);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [DW-1:0] m_i[9];
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [DW-1:0] quat_w_o, quat_x_o, quat_y_o, quat_z_o;
  logic [1:0] branch_used_o;
  logic degenerate_o;
  int   fail_count, pending;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_off = 1'b0;

  initial foreach (m_i[k]) m_i[k] = '0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  rotation_matrix_to_quaternion DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .m00_i(m_i[0]), .m01_i(m_i[1]), .m02_i(m_i[2]),
    .m10_i(m_i[3]), .m11_i(m_i[4]), .m12_i(m_i[5]),
    .m20_i(m_i[6]), .m21_i(m_i[7]), .m22_i(m_i[8]),
    .out_valid_o, .out_stall_i,
    .quat_w_o, .quat_x_o, .quat_y_o, .quat_z_o, .branch_used_o, .degenerate_o
  );

  rmq_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o),
    .m00_i(m_i[0]), .m01_i(m_i[1]), .m02_i(m_i[2]),
    .m10_i(m_i[3]), .m11_i(m_i[4]), .m12_i(m_i[5]),
    .m20_i(m_i[6]), .m21_i(m_i[7]), .m22_i(m_i[8]),
    .out_valid_i(out_valid_o), .out_stall_i,
    .quat_w_i(quat_w_o), .quat_x_i(quat_x_o), .quat_y_i(quat_y_o),
    .quat_z_i(quat_z_o), .branch_used_i(branch_used_o),
    .degenerate_i(degenerate_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random stall each falling edge, or a held-off stretch
  always @(negedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // offer one matrix and hold it until accepted
  task automatic send_matrix(logic signed [DW-1:0] v[9]);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    m_i = v;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  function automatic logic signed [DW-1:0] rand_word();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(2 * ONE)) - ONE;
      2: return ($urandom_range(1)) ? {1'b0, {(DW-1){1'b1}}} : {1'b1, {(DW-1){1'b0}}};
      default: return $signed($urandom_range(64)) - 32;
    endcase
  endfunction

  // mostly a rotation-like matrix: near identity permuted/signed, plus small noise; else random words
  task automatic send_random();
    logic signed [DW-1:0] v[9];
    int p;
    int sg;
    if ($urandom_range(9) < 7) begin
      p = $urandom_range(5);
      foreach (v[k]) v[k] = $signed($urandom_range(ONE / 2)) - ONE / 4;
      for (int r = 0; r < 3; r++) begin
        sg = $urandom_range(1) ? 1 : -1;
        v[r * 3 + ((r + p) % 3)] = sg * (ONE - $urandom_range(ONE / 4));
      end
    end else begin
      foreach (v[k]) v[k] = rand_word();
    end
    send_matrix(v);
  endtask

  task automatic directed();
    logic signed [DW-1:0] v[9];
    logic signed [DW-1:0] mx, mn;
    mx = {1'b0, {(DW-1){1'b1}}};
    mn = {1'b1, {(DW-1){1'b0}}};
    // identity, then each dominant axis
    v = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}; send_matrix(v);
    v = '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}; send_matrix(v);
    v = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE}; send_matrix(v);
    v = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE}; send_matrix(v);
    // diagonal ties
    v = '{-ONE/2, 1, 2, 3, -ONE/2, 5, 6, 7, -ONE/2}; send_matrix(v);
    v = '{0, 1, 2, 3, 0, 5, 6, 7, -ONE/2}; send_matrix(v);
    v = '{-ONE/2, 9, 9, 9, 0, 9, 9, 9, 0}; send_matrix(v);
    // non-positive trace, equal diagonal
    v = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}; send_matrix(v);
    v = '{mn, 0, 0, 0, mn, 0, 0, 0, mn}; send_matrix(v);
    // field extremes, then values near zero
    v = '{mx, mx, mx, mx, mx, mx, mx, mx, mx}; send_matrix(v);
    v = '{mn, mn, mn, mn, mn, mn, mn, mn, mn}; send_matrix(v);
    v = '{1 - ONE, mx, mn, mn, -ONE, mx, mx, mn, -ONE + 1}; send_matrix(v);
    v = '{1, mn, mx, mx, -ONE, mn, mn, mx, -ONE}; send_matrix(v);
    v = '{mx, mn, mx, mn, mn, mx, mn, mx, mn}; send_matrix(v);
    v = '{-1, -1, -1, -1, -1, -1, -1, -1, -1}; send_matrix(v);
    v = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(v);
    v = '{1, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(v);
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    directed();
    // idling phases: none, sender, receiver, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 54 : (ph == 3) ? 27 : 0;
      recv_stall_pct = (ph == 2) ? 54 : (ph == 3) ? 27 : 0;
      repeat (250) send_random();
      // sender pauses until everything has come back
      drain();
    end
    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(negedge clk_i);
        hold_off = 1'b0;
      end
      repeat (100) send_random();
    join
    send_idle_pct = 0; recv_stall_pct = 0;
    drain();
    repeat (80) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule

@@ filelist.f @@
hw/rtl/rmq_pkg.sv
hw/rtl/rmq_front.sv
hw/rtl/rmq_fifo.sv
hw/rtl/rmq_sqrt.sv
hw/rtl/rmq_div.sv
hw/rtl/rotation_matrix_to_quaternion.sv
tb/rmq_checker.sv
tb/tb_rotation_matrix_to_quaternion.sv
